[rtl/bchpc_pkg.sv]
// Shared types and constants for the BCH(31,21) paging codeword corrector.
// Holds the status codes, the correction table entry, the table write port
// and the table builder state encoding. No dependencies.
package bchpc_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_POS   = 32;
  localparam int POS_W     = 5;
  localparam int REM_W     = 10;
  localparam int SYN_W     = 11;
  localparam int POLY_W    = 11;
  localparam int TBL_DEPTH = 2048;

  localparam logic [POLY_W-1:0] POLY_RESET = 11'h769;

  typedef enum logic [1:0] {
    FIX_CLEAN = 2'd0,
    FIX_ONE   = 2'd1,
    FIX_TWO   = 2'd2,
    FIX_NONE  = 2'd3
  } fix_status_t;

  typedef struct packed {
    fix_status_t       status;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
  } tbl_entry_t;

  localparam int ENTRY_W = $bits(tbl_entry_t);

  typedef struct packed {
    logic              we;
    logic [SYN_W-1:0]  addr;
    tbl_entry_t        data;
  } tbl_wr_t;

  typedef logic [NUM_POS-1:0][SYN_W-1:0] col_tbl_t;

  typedef enum logic [2:0] {
    BLD_CLEAR,
    BLD_LOADA,
    BLD_PAIR,
    BLD_SINGLE,
    BLD_ZERO,
    BLD_DONE
  } bld_state_t;

endpackage

[rtl/bchpc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Width and depth are parameters; defaults come from bchpc_pkg.
module bchpc_ram #(
  parameter int WIDTH = bchpc_pkg::ENTRY_W,
  parameter int DEPTH = bchpc_pkg::TBL_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bchpc_builder.sv]
// Correction table builder: derives the per-bit syndrome columns from the
// generator polynomial and fills the syndrome-indexed table. Uses bchpc_pkg.
module bchpc_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic [bchpc_pkg::POLY_W-1:0]     poly,
  output logic                             busy,
  output bchpc_pkg::tbl_wr_t               wr,
  output bchpc_pkg::col_tbl_t              cols
);
  import bchpc_pkg::*;

  bld_state_t        state_r, state_nxt;
  logic [SYN_W-1:0]  addr_r, addr_nxt;
  logic [POS_W-1:0]  a_r, a_nxt;
  logic [POS_W-1:0]  b_r, b_nxt;
  logic [SYN_W-1:0]  ca_r, ca_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  col_tbl_t          cols_r;
  logic [POS_W-1:0]  rd_idx;
  logic [SYN_W-1:0]  col_sel;
  logic [REM_W:0]    rem_shift;

  assign rd_idx  = (state_r == BLD_LOADA) ? a_r : b_r;
  assign col_sel = cols_r[rd_idx];

  always_comb begin
    rem_shift = {rem_r, 1'b0};
    if (rem_shift[REM_W]) begin
      rem_shift = rem_shift ^ poly;
    end
    rem_nxt = rem_shift[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      rem_r <= REM_W'(1);
    end else if (state_r == BLD_CLEAR && addr_r[SYN_W-1:POS_W] == '0) begin
      if (addr_r == '0) begin
        cols_r[addr_r[POS_W-1:0]] <= {1'b1, REM_W'(0)};
      end else begin
        cols_r[addr_r[POS_W-1:0]] <= {1'b1, rem_r};
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_CLEAR;
      addr_r  <= '0;
      a_r     <= '0;
      b_r     <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ca_r <= ca_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ca_nxt    = ca_r;
    wr        = '0;
    case (state_r)
      BLD_CLEAR: begin
        wr.we          = 1'b1;
        wr.addr        = addr_r;
        wr.data.status = FIX_NONE;
        addr_nxt       = addr_r + 1'b1;
        if (addr_r == SYN_W'(TBL_DEPTH - 1)) begin
          state_nxt = BLD_LOADA;
          a_nxt     = POS_W'(NUM_POS - 2);
        end
      end
      BLD_LOADA: begin
        ca_nxt    = col_sel;
        b_nxt     = POS_W'(NUM_POS - 1);
        state_nxt = BLD_PAIR;
      end
      BLD_PAIR: begin
        wr.we          = 1'b1;
        wr.addr        = ca_r ^ col_sel;
        wr.data.status = FIX_TWO;
        wr.data.pos_a  = a_r;
        wr.data.pos_b  = b_r;
        if (b_r == a_r + 1'b1) begin
          if (a_r == '0) begin
            state_nxt = BLD_SINGLE;
            b_nxt     = POS_W'(NUM_POS - 1);
          end else begin
            a_nxt     = a_r - 1'b1;
            state_nxt = BLD_LOADA;
          end
        end else begin
          b_nxt = b_r - 1'b1;
        end
      end
      BLD_SINGLE: begin
        wr.we          = 1'b1;
        wr.addr        = col_sel;
        wr.data.status = FIX_ONE;
        wr.data.pos_a  = b_r;
        if (b_r == '0) begin
          state_nxt = BLD_ZERO;
        end else begin
          b_nxt = b_r - 1'b1;
        end
      end
      BLD_ZERO: begin
        wr.we          = 1'b1;
        wr.addr        = '0;
        wr.data.status = FIX_CLEAN;
        state_nxt      = BLD_DONE;
      end
      BLD_DONE: begin
        state_nxt = BLD_DONE;
      end
      default: begin
        state_nxt = BLD_CLEAR;
        addr_nxt  = '0;
      end
    endcase
    if (restart) begin
      state_nxt = BLD_CLEAR;
      addr_nxt  = '0;
    end
  end

  assign busy = (state_r != BLD_DONE);
  assign cols = cols_r;

endmodule

[rtl/bch_31_21_parity_corrector_unit.sv]
// Top level of the BCH(31,21) paging codeword corrector with even parity bit.
// Uses bchpc_pkg, bchpc_builder and bchpc_ram.
//
// Input: a codeword beat is taken at a rising edge with start high and busy
// low. One beat per cycle is taken while busy is low.
// Output: out_valid strobes for one cycle, registered through s1_valid_r and
// out_valid_r, with out_corrected_word and out_fix_status (0 clean, 1 one bit
// fixed, 2 two bits fixed, 3 uncorrectable, word passed unchanged). The
// receiver cannot stall; results leave in input order at the input rate.
// Configuration: cfg_ready is always high; a beat on cfg_valid loads the
// generator polynomial and rebuilds the correction table.
// Throughput is set by the single read port of the 2048-entry correction
// table, addressed by the 11-bit syndrome: one codeword per cycle while
// busy is low. After reset and after each configuration beat, busy stays
// high while the builder clears all 2048 table entries and makes 31 column
// loads, 496 pair writes, 32 single-bit writes and one clean-syndrome write.
// A polynomial without bit 10 set bypasses the table: only words of weight
// two or less are then correctable, to all zeros.
module bch_31_21_parity_corrector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bchpc_pkg::WORD_W-1:0]   in_codeword,
  output logic                           out_valid,
  output logic [bchpc_pkg::WORD_W-1:0]   out_corrected_word,
  output logic [1:0]                     out_fix_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bchpc_pkg::POLY_W-1:0]   cfg_generator_poly
);
  import bchpc_pkg::*;

  logic [POLY_W-1:0]  poly_r;
  logic               cfg_wr;
  logic               bld_busy;
  tbl_wr_t            tbl_wr;
  col_tbl_t           cols;
  logic               accept;
  logic [SYN_W-1:0]   syn;
  logic [WORD_W-1:0]  low1, low2;
  fix_status_t        wcls;
  logic [ENTRY_W-1:0] rd_data;
  tbl_entry_t         ent;

  logic               s1_valid_r;
  logic [WORD_W-1:0]  s1_word_r;
  logic               s1_degen_r;
  fix_status_t        s1_wcls_r;

  logic               out_valid_r;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  fix_status_t        out_status_r, out_status_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = bld_busy;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
    end else if (cfg_wr) begin
      poly_r <= cfg_generator_poly;
    end
  end

  bchpc_builder u_builder (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .poly    (poly_r),
    .busy    (bld_busy),
    .wr      (tbl_wr),
    .cols    (cols)
  );

  always_comb begin
    syn = '0;
    for (int k = 0; k < NUM_POS; k++) begin
      if (in_codeword[k]) begin
        syn = syn ^ cols[k];
      end
    end
  end

  bchpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_wr.we),
    .wr_addr (tbl_wr.addr),
    .wr_data (tbl_wr.data),
    .rd_en   (accept),
    .rd_addr (syn),
    .rd_data (rd_data)
  );

  always_comb begin
    low1 = in_codeword & (in_codeword - 1'b1);
    low2 = low1 & (low1 - 1'b1);
    if (in_codeword == '0) begin
      wcls = FIX_CLEAN;
    end else if (low1 == '0) begin
      wcls = FIX_ONE;
    end else if (low2 == '0) begin
      wcls = FIX_TWO;
    end else begin
      wcls = FIX_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r  <= in_codeword;
      s1_degen_r <= !poly_r[REM_W];
      s1_wcls_r  <= wcls;
    end
  end

  assign ent = tbl_entry_t'(rd_data);

  always_comb begin
    out_word_nxt   = s1_word_r;
    out_status_nxt = ent.status;
    if (s1_degen_r) begin
      out_status_nxt = s1_wcls_r;
      if (s1_wcls_r != FIX_NONE) begin
        out_word_nxt = '0;
      end
    end else begin
      if (ent.status inside {FIX_ONE, FIX_TWO}) begin
        out_word_nxt = out_word_nxt ^ (WORD_W'(1) << ent.pos_a);
      end
      if (ent.status == FIX_TWO) begin
        out_word_nxt = out_word_nxt ^ (WORD_W'(1) << ent.pos_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_word_r   <= out_word_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_corrected_word = out_word_r;
  assign out_fix_status     = out_status_r;

endmodule

[rtl/bchpc_checker.sv]
// Port-level checker for the BCH(31,21) corrector, bound to the top level.
// Uses bchpc_pkg status codes.
module bchpc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [bchpc_pkg::WORD_W-1:0]   in_codeword,
  input logic                           out_valid,
  input logic [bchpc_pkg::WORD_W-1:0]   out_corrected_word,
  input logic [1:0]                     out_fix_status
);
  import bchpc_pkg::*;

  a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  a_unchanged_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fix_status == FIX_CLEAN || out_fix_status == FIX_NONE)
      |-> out_corrected_word == $past(in_codeword, 2))
    else $error("clean or uncorrectable word was altered");

  a_one_bit_fix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_status == FIX_ONE
      |-> $countones(out_corrected_word ^ $past(in_codeword, 2)) == 1)
    else $error("one-bit fix changed a wrong number of bits");

  a_two_bit_fix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_status == FIX_TWO
      |-> $countones(out_corrected_word ^ $past(in_codeword, 2)) == 2)
    else $error("two-bit fix changed a wrong number of bits");

endmodule

bind bch_31_21_parity_corrector_unit bchpc_checker u_chk (.*);

[tb/bchpc_fix_checker.sv]
// Checker for the BCH(31,21) paging codeword corrector: watches the codeword, result
// and polynomial channels, predicts each corrected word and status, and counts mismatches.
// Depends on bchpc_pkg for widths, the polynomial reset value and the status codes.
module bchpc_fix_checker
  import bchpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [WORD_W-1:0] in_codeword,
  input  logic              out_valid,
  input  logic [WORD_W-1:0] out_corrected_word,
  input  logic [1:0]        out_fix_status,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [POLY_W-1:0] cfg_generator_poly,
  output int                mismatch_count,
  output int                fixes_owed
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    fix_status_t       status;
  } fix_t;

  logic [POLY_W-1:0] poly = POLY_RESET;
  fix_t              owed_fixes [$];
  int                mismatches = 0;
  int                owed_count = 0;

  assign mismatch_count = mismatches;
  assign fixes_owed     = owed_count;

  function automatic logic [30:0] poly_remainder(logic [WORD_W-1:0] w, logic [POLY_W-1:0] g);
    logic [30:0] r;
    logic [30:0] d;
    r = w[31:1];
    d = 31'(g) << 20;
    for (int s = 0; s < 21; s++) begin
      if (r[30-s]) r ^= d;
      d >>= 1;
    end
    return r;
  endfunction

  // The remainder is linear over GF(2), so flips are tried as XORs of per-bit remainders;
  // a zero syndrome needs both a zero remainder and even weight.
  function automatic fix_t predict_fix(logic [WORD_W-1:0] w, logic [POLY_W-1:0] g);
    logic [30:0] col [NUM_POS];
    logic [30:0] r0;
    logic        odd;
    fix_t        f;
    f.word   = w;
    f.status = FIX_NONE;
    r0  = poly_remainder(w, g);
    odd = ^w;
    if (r0 == '0 && !odd) begin
      f.status = FIX_CLEAN;
      return f;
    end
    for (int i = 0; i < NUM_POS; i++) col[i] = poly_remainder(WORD_W'(1) << i, g);
    if (odd) begin
      for (int i = 0; i < NUM_POS; i++) begin
        if ((r0 ^ col[i]) == '0) begin
          f.word   = w ^ (WORD_W'(1) << i);
          f.status = FIX_ONE;
          return f;
        end
      end
    end else begin
      for (int i = 0; i < NUM_POS; i++) begin
        for (int j = i + 1; j < NUM_POS; j++) begin
          if ((r0 ^ col[i] ^ col[j]) == '0) begin
            f.word   = w ^ (WORD_W'(1) << i) ^ (WORD_W'(1) << j);
            f.status = FIX_TWO;
            return f;
          end
        end
      end
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (mismatches < 60)
      $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    fix_t want;
    if (!rst_n) begin
      poly = POLY_RESET;
      owed_fixes.delete();
    end else begin
      if (out_valid) begin
        if (owed_fixes.size() == 0) begin
          report_mismatch("unexpected result beat", out_corrected_word, '0);
        end else begin
          want = owed_fixes.pop_front();
          if (out_corrected_word !== want.word)
            report_mismatch("corrected_word", out_corrected_word, want.word);
          if (out_fix_status !== want.status)
            report_mismatch("fix_status", WORD_W'(out_fix_status), WORD_W'(want.status));
        end
      end
      if (start && !busy) owed_fixes.push_back(predict_fix(in_codeword, poly));
      if (cfg_valid && cfg_ready) poly = cfg_generator_poly;
    end
    owed_count = owed_fixes.size();
  end

endmodule

[tb/tb_bch_31_21_parity_corrector_unit.sv]
// Testbench top for the BCH(31,21) paging codeword corrector: drives codeword beats
// and polynomial writes, and gives the verdict from the failure count of the checker.
// Depends on bchpc_pkg, bch_31_21_parity_corrector_unit and bchpc_fix_checker.
module tb_bch_31_21_parity_corrector_unit;
  import bchpc_pkg::*;

  localparam int CYCLE_LIMIT = 250000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [WORD_W-1:0] in_codeword = '0;
  logic              cfg_valid = 1'b0;
  logic [POLY_W-1:0] cfg_generator_poly = '0;
  logic              busy;
  logic              out_valid;
  logic [WORD_W-1:0] out_corrected_word;
  logic [1:0]        out_fix_status;
  logic              cfg_ready;
  int                mismatch_count;
  int                fixes_owed;
  int                cycles = 0;

  bch_31_21_parity_corrector_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_codeword        (in_codeword),
    .out_valid          (out_valid),
    .out_corrected_word (out_corrected_word),
    .out_fix_status     (out_fix_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_generator_poly (cfg_generator_poly)
  );

  bchpc_fix_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_codeword        (in_codeword),
    .out_valid          (out_valid),
    .out_corrected_word (out_corrected_word),
    .out_fix_status     (out_fix_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_generator_poly (cfg_generator_poly),
    .mismatch_count     (mismatch_count),
    .fixes_owed         (fixes_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Multiply the message by the generator so the word divides cleanly when g is monic.
  function automatic logic [WORD_W-1:0] encode(logic [20:0] msg, logic [POLY_W-1:0] g);
    logic [30:0] c;
    c = '0;
    for (int i = 0; i < 21; i++) begin
      if (msg[i]) c ^= 31'(g) << i;
    end
    return {c, ^c};
  endfunction

  function automatic logic [WORD_W-1:0] random_word(logic [POLY_W-1:0] g);
    logic [WORD_W-1:0] w;
    int                kind;
    int                flips;
    int                pos;
    kind = $urandom_range(99);
    if (kind < 10) return $urandom();
    w = encode(21'($urandom()), g);
    flips = (kind < 25) ? 0 : (kind < 55) ? 1 : (kind < 85) ? 2 : $urandom_range(3, 6);
    repeat (flips) begin
      pos = $urandom_range(WORD_W - 1);
      w[pos] = ~w[pos];
    end
    return w;
  endfunction

  task automatic send_word(logic [WORD_W-1:0] w);
    @(negedge clk);
    start       <= 1'b1;
    in_codeword <= w;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      in_codeword <= $urandom();
    end
  endtask

  task automatic drain_fixes();
    @(negedge clk);
    start <= 1'b0;
    while (fixes_owed != 0) @(negedge clk);
  endtask

  task automatic write_poly(logic [POLY_W-1:0] g);
    drain_fixes();
    cfg_valid          <= 1'b1;
    cfg_generator_poly <= g;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Run a stretch of random beats; idle pressure changes every few dozen beats.
  task automatic run_random(int count, logic [POLY_W-1:0] g, int quiet_tail);
    int idle_pct;
    idle_pct = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0)
        idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
      if (k >= count - quiet_tail) idle_pct = 0;
      send_word(random_word(g));
      if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 14));
    end
  endtask

  initial begin
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] directed [$];
    base = encode(21'h0B3C5, POLY_RESET);
    directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h0000_0002, 32'h0000_0003, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                 32'hAAAA_AAAA, 32'h5555_5555, encode(21'h1F_FFFF, POLY_RESET),
                 base, base ^ 32'h1, base ^ 32'h8000_0000, base ^ 32'h8000_0001,
                 base ^ 32'h0002_0020, base ^ 32'h0000_0400, base ^ 32'h1004_0100,
                 base ^ 32'h0F00_0000, base ^ 32'h0000_0006};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      send_word(directed[k]);
      if (k % 3 == 0) hold_off($urandom_range(1, 14));
    end
    run_random(600, POLY_RESET, 0);

    write_poly(11'h7FF);
    run_random(150, 11'h7FF, 0);
    write_poly(11'h000);
    run_random(150, 11'h000, 0);
    write_poly(11'h400);
    run_random(150, 11'h400, 0);
    write_poly(11'h3FF);
    run_random(150, 11'h3FF, 0);
    base[POLY_W-1:0] = {1'b1, 10'($urandom())};
    write_poly(base[POLY_W-1:0]);
    run_random(250, base[POLY_W-1:0], 0);
    write_poly(POLY_RESET);
    run_random(500, POLY_RESET, 200);

    drain_fixes();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bchpc_pkg.sv
rtl/bchpc_ram.sv
rtl/bchpc_builder.sv
rtl/bch_31_21_parity_corrector_unit.sv
rtl/bchpc_checker.sv
tb/bchpc_fix_checker.sv
tb/tb_bch_31_21_parity_corrector_unit.sv
